FILE: design/fqs_pkg.sv
// shared codes and defaults for the fifo queue with search
package fqs_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int WORD_W   = 32;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ    = 3'd0,
    OP_DEQ    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_FIND   = 3'd3,
    OP_COUNT  = 3'd4,
    OP_REMOVE = 3'd5,
    OP_CLEAR  = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

endpackage

FILE: design/fifo_queue_with_search.sv
// fifo queue of signed words with find, count and remove-matches requests
//
// Slave channel: one request per transaction, operation in s_tuser and the
// word or search key in s_tdata. Master channel: exactly one result per
// request, status in m_tuser, head word, match position, match count and
// fill level in m_tdata.
// Requests run one at a time under a small sequencer around a store with one
// read and one write port and one 32-bit comparator; s_tready is high only
// while idle. Enqueue, clear and unused codes go straight to the result
// stage; dequeue and peek first take one registered store read.
// Find, count and remove walk the stored entries head to tail, one entry per
// cycle through the comparator; find stops at the first match.
// The result waits in an output register; while m_tready is low the block
// holds it and finishes the next request up to the result stage.
// Reset empties the queue (head, tail and fill level zero) and drops any
// pending result; the store itself is not cleared.
module fifo_queue_with_search #(
  parameter int DEPTH = fqs_pkg::DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1),
  localparam int MDW = ((fqs_pkg::WORD_W + 3 * CW + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [fqs_pkg::WORD_W-1:0]    s_tdata,  // value
  input  logic [fqs_pkg::OP_W-1:0]      s_tuser,  // operation
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [MDW-1:0]                m_tdata,  // word_out, position, matches_res, fill_level
  output logic [fqs_pkg::STATUS_W-1:0]  m_tuser   // status
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_HEAD = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;

  logic [fqs_pkg::WORD_W-1:0] mem [DEPTH];
  logic [fqs_pkg::WORD_W-1:0] rdata;
  logic [AW-1:0]              raddr;
  logic                       we;
  logic [AW-1:0]              waddr;
  logic [fqs_pkg::WORD_W-1:0] wdata;

  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [CW-1:0] occ;
  logic [AW-1:0] rd_slot;
  logic [AW-1:0] wr_slot;
  logic [AW-1:0] proc;
  logic [CW-1:0] kept;

  fqs_pkg::op_t               cur_op;
  logic [fqs_pkg::WORD_W-1:0] key;
  logic [fqs_pkg::WORD_W-1:0] res_word;
  fqs_pkg::status_t           res_status;
  logic [CW-1:0]              res_pos;
  logic [CW-1:0]              res_hits;

  logic         s_fire;
  logic         full;
  logic         match;
  logic         last;
  logic         enq_wr;
  logic         scan_wr;
  fqs_pkg::op_t in_op;
  logic [CW:0]  chk_sum;
  logic [CW:0]  chk_tail;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x);
    logic [AW-1:0] r;
    r = (x == AW'(DEPTH - 1)) ? '0 : x + AW'(1);
    return r;
  endfunction

  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign in_op    = fqs_pkg::op_t'(s_tuser);
  assign full     = (occ == CW'(DEPTH));
  assign match    = (rdata == key);
  assign last     = ((CW'(proc) + CW'(1)) == occ);
  assign raddr    = (state == S_SCAN) ? rd_slot : head;

  assign enq_wr  = s_fire && (in_op == fqs_pkg::OP_ENQ) && !full;
  assign scan_wr = (state == S_SCAN) && (cur_op == fqs_pkg::OP_REMOVE) && !match;
  assign we      = enq_wr || scan_wr;
  assign waddr   = scan_wr ? wr_slot : tail;
  assign wdata   = scan_wr ? rdata : s_tdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      tail     <= '0;
      occ      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_fire) begin
            cur_op     <= in_op;
            key        <= s_tdata;
            res_word   <= '0;
            res_pos    <= '0;
            res_hits   <= '0;
            rd_slot    <= wrap_inc(head);
            wr_slot    <= head;
            proc       <= '0;
            kept       <= '0;
            unique case (in_op)
              fqs_pkg::OP_ENQ: begin
                state <= S_DONE;
                if (full) begin
                  res_status <= fqs_pkg::ST_FULL;
                end else begin
                  res_status <= fqs_pkg::ST_OK;
                  tail       <= wrap_inc(tail);
                  occ        <= occ + CW'(1);
                end
              end
              fqs_pkg::OP_DEQ, fqs_pkg::OP_PEEK: begin
                res_status <= fqs_pkg::ST_OK;
                state      <= S_HEAD;
              end
              fqs_pkg::OP_FIND: begin
                if (occ == '0) begin
                  res_status <= fqs_pkg::ST_MISS;
                  state      <= S_DONE;
                end else begin
                  res_status <= fqs_pkg::ST_OK;
                  state      <= S_SCAN;
                end
              end
              fqs_pkg::OP_COUNT, fqs_pkg::OP_REMOVE: begin
                res_status <= fqs_pkg::ST_OK;
                state      <= (occ != '0) ? S_SCAN : S_DONE;
              end
              fqs_pkg::OP_CLEAR: begin
                res_status <= fqs_pkg::ST_OK;
                state      <= S_DONE;
                head       <= '0;
                tail       <= '0;
                occ        <= '0;
              end
              default: begin
                res_status <= fqs_pkg::ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_HEAD: begin
          if (occ == '0) begin
            res_status <= fqs_pkg::ST_EMPTY;
          end else begin
            res_word <= rdata;
            if (cur_op == fqs_pkg::OP_DEQ) begin
              head <= wrap_inc(head);
              occ  <= occ - CW'(1);
            end
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          rd_slot <= wrap_inc(rd_slot);
          proc    <= proc + AW'(1);
          unique case (cur_op)
            fqs_pkg::OP_FIND: begin
              if (match) begin
                res_pos <= CW'(proc) + CW'(1);
                state   <= S_DONE;
              end else if (last) begin
                res_status <= fqs_pkg::ST_MISS;
                state      <= S_DONE;
              end
            end
            fqs_pkg::OP_COUNT: begin
              if (match) begin
                res_hits <= res_hits + CW'(1);
              end
              if (last) begin
                state <= S_DONE;
              end
            end
            default: begin
              if (match) begin
                res_hits <= res_hits + CW'(1);
              end else begin
                wr_slot <= wrap_inc(wr_slot);
                kept    <= kept + CW'(1);
              end
              if (last) begin
                occ   <= match ? kept : kept + CW'(1);
                tail  <= match ? wr_slot : wrap_inc(wr_slot);
                state <= S_DONE;
              end
            end
          endcase
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= MDW'({occ, res_hits, res_pos, res_word});
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ring bookkeeping check
  assign chk_sum  = (CW + 1)'(head) + (CW + 1)'(occ);
  assign chk_tail = (CW + 1)'(tail);

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(DEPTH))
    else $error("fill level above depth");

  a_ring: assert property (@(posedge clk) disable iff (rst)
    (chk_sum == chk_tail) || (chk_sum == chk_tail + (CW + 1)'(DEPTH)))
    else $error("tail does not follow head plus fill level");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (CW'(proc) < occ))
    else $error("walk past the stored entries");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> !s_tready)
    else $error("request taken while another is in progress");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!m_tvalid || m_tready)) |=> m_tvalid && s_tready)
    else $error("finished result not presented");

endmodule

FILE: tb/fifo_queue_with_search_checker.sv
// checker for the fifo queue with search: predicts each request and compares results
module fifo_queue_with_search_checker #(
  parameter int DEPTH = fqs_pkg::DEPTH_DEFAULT,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int MDW = ((fqs_pkg::WORD_W + 3 * CW + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [fqs_pkg::WORD_W-1:0]   s_tdata,  // value
  input  logic [fqs_pkg::OP_W-1:0]     s_tuser,  // operation
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [MDW-1:0]               m_tdata,  // word_out, position, matches_res, fill_level
  input  logic [fqs_pkg::STATUS_W-1:0] m_tuser,  // status
  output int                           fail_count,
  output int                           outstanding,
  output int                           results_seen
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [fqs_pkg::WORD_W-1:0] word;
    fqs_pkg::status_t           status;
    logic [CW-1:0]              position;
    logic [CW-1:0]              hit_count;
    logic [CW-1:0]              fill;
  } queue_result_t;

  logic [fqs_pkg::WORD_W-1:0] model_entries [DEPTH];
  int model_head;
  int model_fill;
  queue_result_t pending_results [$];

  initial begin
    fail_count = 0;
    results_seen = 0;
    outstanding = 0;
    model_head = 0;
    model_fill = 0;
  end

  function automatic queue_result_t predict_queue_op(logic [fqs_pkg::OP_W-1:0] op,
                                                     logic [fqs_pkg::WORD_W-1:0] key);
    queue_result_t r;
    int n;
    int kept;
    bit found;
    logic [fqs_pkg::WORD_W-1:0] w;
    r = '0;
    r.status = fqs_pkg::ST_OK;
    found = 0;
    kept = 0;
    case (op)
      fqs_pkg::OP_ENQ: begin
        if (model_fill >= DEPTH) begin
          r.status = fqs_pkg::ST_FULL;
        end else begin
          model_entries[(model_head + model_fill) % DEPTH] = key;
          model_fill++;
        end
      end
      fqs_pkg::OP_DEQ, fqs_pkg::OP_PEEK: begin
        if (model_fill == 0) begin
          r.status = fqs_pkg::ST_EMPTY;
        end else begin
          r.word = model_entries[model_head];
          if (op == fqs_pkg::OP_DEQ) begin
            model_head = (model_head + 1) % DEPTH;
            model_fill--;
          end
        end
      end
      fqs_pkg::OP_FIND: begin
        r.status = fqs_pkg::ST_MISS;
        for (n = 0; n < model_fill; n++) begin
          if (!found && model_entries[(model_head + n) % DEPTH] == key) begin
            found = 1;
            r.position = CW'(n + 1);
            r.status = fqs_pkg::ST_OK;
          end
        end
      end
      fqs_pkg::OP_COUNT: begin
        for (n = 0; n < model_fill; n++)
          if (model_entries[(model_head + n) % DEPTH] == key) r.hit_count++;
      end
      fqs_pkg::OP_REMOVE: begin
        for (n = 0; n < model_fill; n++) begin
          w = model_entries[(model_head + n) % DEPTH];
          if (w == key) begin
            r.hit_count++;
          end else begin
            model_entries[(model_head + kept) % DEPTH] = w;
            kept++;
          end
        end
        model_fill = kept;
      end
      fqs_pkg::OP_CLEAR: begin
        model_head = 0;
        model_fill = 0;
      end
      default: ;
    endcase
    r.fill = CW'(model_fill);
    return r;
  endfunction

  always @(posedge clk) begin
    queue_result_t exp_r;
    logic [fqs_pkg::WORD_W-1:0] got_word;
    logic [CW-1:0] got_pos;
    logic [CW-1:0] got_matches;
    logic [CW-1:0] got_fill;
    if (rst) begin
      pending_results.delete();
      model_head = 0;
      model_fill = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        got_word = m_tdata[fqs_pkg::WORD_W-1:0];
        got_pos = m_tdata[fqs_pkg::WORD_W +: CW];
        got_matches = m_tdata[fqs_pkg::WORD_W + CW +: CW];
        got_fill = m_tdata[fqs_pkg::WORD_W + 2 * CW +: CW];
        if (pending_results.size() == 0) begin
          $error("result transaction with no request pending");
          fail_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (got_word !== exp_r.word) begin
            $error("word_out expected %h actual %h", exp_r.word, got_word);
            fail_count++;
          end
          if (m_tuser !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, m_tuser);
            fail_count++;
          end
          if (got_pos !== exp_r.position) begin
            $error("position expected %0d actual %0d", exp_r.position, got_pos);
            fail_count++;
          end
          if (got_matches !== exp_r.hit_count) begin
            $error("matches_res expected %0d actual %0d", exp_r.hit_count, got_matches);
            fail_count++;
          end
          if (got_fill !== exp_r.fill) begin
            $error("fill_level expected %0d actual %0d", exp_r.fill, got_fill);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready)
        pending_results.push_back(predict_queue_op(s_tuser, s_tdata));
    end
    outstanding = pending_results.size();
  end

endmodule

FILE: tb/fifo_queue_with_search_tb.sv
// testbench top for the fifo queue with search: stimulus, back-pressure and verdict
module fifo_queue_with_search_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = fqs_pkg::DEPTH_DEFAULT;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MDW = ((fqs_pkg::WORD_W + 3 * CW + 7) / 8) * 8;
  localparam logic [fqs_pkg::OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int RANDOM_REQUESTS = 1520;
  localparam int QUIET_TAIL = 200;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [fqs_pkg::WORD_W-1:0] s_tdata;    // value
  logic [fqs_pkg::OP_W-1:0] s_tuser;      // operation
  logic m_tvalid;
  logic m_tready;
  logic [MDW-1:0] m_tdata;                // word_out, position, matches_res, fill_level
  logic [fqs_pkg::STATUS_W-1:0] m_tuser;  // status

  int fail_count;
  int outstanding;
  int results_seen;
  int cycles;
  int ops_sent [8];
  bit quiet;
  bit long_hold;
  logic [fqs_pkg::WORD_W-1:0] key_pool [8];

  fifo_queue_with_search #(.DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  fifo_queue_with_search_checker #(.DEPTH(DEPTH)) queue_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .outstanding(outstanding), .results_seen(results_seen)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("fifo_queue_with_search regression: fail");
        $finish;
      end
    end
  end

  task automatic send_request(logic [fqs_pkg::OP_W-1:0] op,
                              logic [fqs_pkg::WORD_W-1:0] val);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= val;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ops_sent[op]++;
  endtask

  task automatic idle_sender(int n, bit drain);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
    if (drain)
      while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [fqs_pkg::OP_W-1:0] pick_op(bit fill_phase);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < (fill_phase ? 55 : 25)) return fqs_pkg::OP_ENQ;
    if (roll < (fill_phase ? 63 : 50)) return fqs_pkg::OP_DEQ;
    if (roll < 70) return fqs_pkg::OP_PEEK;
    if (roll < 80) return fqs_pkg::OP_FIND;
    if (roll < 88) return fqs_pkg::OP_COUNT;
    if (roll < 95) return fqs_pkg::OP_REMOVE;
    if (roll < 98) return fqs_pkg::OP_CLEAR;
    return OP_UNUSED;
  endfunction

  function automatic logic [fqs_pkg::WORD_W-1:0] pick_value();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return key_pool[$urandom_range(0, 7)];
  endfunction

  // receiver: random stalls, one long hold-off on request, none in the tail
  initial begin
    m_tready = 1'b0;
    wait (!rst);
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    bit fill_phase;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = fqs_pkg::OP_ENQ;
    quiet = 0;
    long_hold = 0;
    fill_phase = 1;
    foreach (ops_sent[i]) ops_sent[i] = 0;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 8; i++) key_pool[i] = $urandom;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty store corner cases and the unused code
    send_request(fqs_pkg::OP_DEQ, 32'h0);
    send_request(fqs_pkg::OP_PEEK, 32'hffff_ffff);
    send_request(fqs_pkg::OP_FIND, 32'h8000_0000);
    send_request(fqs_pkg::OP_COUNT, 32'h0);
    send_request(fqs_pkg::OP_REMOVE, 32'h7fff_ffff);
    send_request(OP_UNUSED, 32'h1234_5678);
    // fill to the brim with extremes and repeats, then one refused enqueue
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0: send_request(fqs_pkg::OP_ENQ, 32'h8000_0000);
        1: send_request(fqs_pkg::OP_ENQ, 32'h7fff_ffff);
        2: send_request(fqs_pkg::OP_ENQ, (i < 8) ? 32'h0 : 32'hffff_ffff);
        default: send_request(fqs_pkg::OP_ENQ, 32'h5);
      endcase
    end
    send_request(fqs_pkg::OP_ENQ, 32'h1);
    send_request(fqs_pkg::OP_FIND, 32'h7fff_ffff);
    send_request(fqs_pkg::OP_FIND, 32'h1);
    send_request(fqs_pkg::OP_COUNT, 32'h5);
    send_request(fqs_pkg::OP_REMOVE, 32'h8000_0000);
    send_request(fqs_pkg::OP_PEEK, 32'h0);
    send_request(fqs_pkg::OP_DEQ, 32'h0);
    send_request(fqs_pkg::OP_CLEAR, 32'h0);
    idle_sender(1, 1);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 60 == 0) fill_phase = $urandom_range(0, 1);
      if (n == RANDOM_REQUESTS - QUIET_TAIL) quiet = 1;
      if (n == 400) long_hold = 1;
      send_request(pick_op(fill_phase), pick_value());
      if (n == 800)
        idle_sender(1, 1);
      else if (!quiet && $urandom_range(0, 5) == 0)
        idle_sender($urandom_range(1, 11), 0);
    end
    idle_sender(1, 1);
    repeat (40) @(posedge clk);

    $display("covered %0d enqueue, %0d dequeue, %0d peek, %0d find, %0d count requests",
             ops_sent[fqs_pkg::OP_ENQ], ops_sent[fqs_pkg::OP_DEQ],
             ops_sent[fqs_pkg::OP_PEEK], ops_sent[fqs_pkg::OP_FIND],
             ops_sent[fqs_pkg::OP_COUNT]);
    $display("plus %0d remove, %0d clear, %0d unused code; %0d results checked",
             ops_sent[fqs_pkg::OP_REMOVE], ops_sent[fqs_pkg::OP_CLEAR],
             ops_sent[OP_UNUSED], results_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("fifo_queue_with_search regression: pass");
    end else begin
      $display("fifo_queue_with_search regression: fail");
    end
    $finish;
  end

endmodule
